[hdl/jst_pkg.sv]
// Shared types, codes and character tables for the source tokenizer.
// Depends on nothing; jst_ctrl, jst_dp, the top and jst_checker import it.
`default_nettype none
package jst_pkg;

   localparam int KW_COUNT   = 21;
   localparam int KW_MAX_LEN = 11;

   localparam logic [2:0] KIND_KEYWORD  = 3'd0;
   localparam logic [2:0] KIND_SYMBOL   = 3'd1;
   localparam logic [2:0] KIND_IDENT    = 3'd2;
   localparam logic [2:0] KIND_INTEGER  = 3'd3;
   localparam logic [2:0] KIND_STR_CHAR = 3'd4;
   localparam logic [2:0] KIND_STR_END  = 3'd5;
   localparam logic [2:0] KIND_END      = 3'd6;
   localparam logic [2:0] KIND_ERROR    = 3'd7;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_INVALID  = 3'd1;
   localparam logic [2:0] ERR_NL_STR   = 3'd2;
   localparam logic [2:0] ERR_UNCLOSED = 3'd3;
   localparam logic [2:0] ERR_LONG_ID  = 3'd4;
   localparam logic [2:0] ERR_OVERFLOW = 3'd5;

   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_US    = 8'h5F;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;

   localparam logic [14:0] INT_MAX  = 15'h7FFF;
   localparam logic [15:0] LINE_MAX = 16'hFFFF;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_SLASH, MODE_LINE, MODE_BLOCK, MODE_ANGLE,
      MODE_STRING, MODE_NUMBER, MODE_WORD, MODE_HALT
   } scan_mode_type;

   typedef enum logic [2:0] {
      ST_WAIT, ST_MODE, ST_RUN, ST_IDLE, ST_END
   } ctrl_state_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_MODE, OP_IDLE, OP_RUN, OP_END
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      fire;
      logic      take;
   } dp_cmd_type;

   typedef struct packed {
      logic emit;
      logic slot_free;
      logic redispatch;
      logic start_run;
      logic run_done;
      logic is_end;
   } dp_status_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_word_char(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_US);
   endfunction

   function automatic logic is_symbol(logic [7:0] c);
      logic r;
      case (c)
         8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2E, 8'h2C, 8'h3B, 8'h2B,
         8'h2D, 8'h2A, 8'h2F, 8'h26, 8'h7C, 8'h3C, 8'h3E, 8'h3D, 8'h7E: begin
            r = 1'b1;
         end
         default: begin
            r = 1'b0;
         end
      endcase
      return r;
   endfunction

   // true when the idle dispatch of c produces a result of its own
   function automatic logic idle_emits(logic [7:0] c);
      logic quiet;
      quiet = is_space(c) || (c == CH_SLASH) || (c == CH_LT) || (c == CH_GT) ||
              (c == CH_QUOTE) || is_word_char(c);
      return !quiet;
   endfunction

   function automatic logic [7:0] to_lower(logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
   endfunction

   // keyword text, last character in the low byte
   function automatic logic [8*KW_MAX_LEN-1:0] kw_word(int k);
      logic [8*KW_MAX_LEN-1:0] w;
      case (k)
         0:       w = 88'("class");
         1:       w = 88'("method");
         2:       w = 88'("function");
         3:       w = 88'("constructor");
         4:       w = 88'("int");
         5:       w = 88'("boolean");
         6:       w = 88'("char");
         7:       w = 88'("void");
         8:       w = 88'("var");
         9:       w = 88'("static");
         10:      w = 88'("field");
         11:      w = 88'("let");
         12:      w = 88'("do");
         13:      w = 88'("if");
         14:      w = 88'("else");
         15:      w = 88'("while");
         16:      w = 88'("return");
         17:      w = 88'("true");
         18:      w = 88'("false");
         19:      w = 88'("null");
         default: w = 88'("this");
      endcase
      return w;
   endfunction

   function automatic int kw_len(int k);
      int n;
      case (k)
         0:       n = 5;
         1:       n = 6;
         2:       n = 8;
         3:       n = 11;
         4:       n = 3;
         5:       n = 7;
         6:       n = 4;
         7:       n = 4;
         8:       n = 3;
         9:       n = 6;
         10:      n = 5;
         11:      n = 3;
         12:      n = 2;
         13:      n = 2;
         14:      n = 4;
         15:      n = 5;
         16:      n = 6;
         17:      n = 4;
         18:      n = 5;
         19:      n = 4;
         default: n = 4;
      endcase
      return n;
   endfunction

   // character at position pos of keyword k, zero past its end
   function automatic logic [7:0] kw_char(int k, int pos);
      logic [8*KW_MAX_LEN-1:0] w;
      int                      n;
      w = kw_word(k);
      n = kw_len(k);
      if (pos < n) begin
         return w[8*(n-1-pos) +: 8];
      end
      return 8'd0;
   endfunction

endpackage
`default_nettype wire

[hdl/jst_req_if.sv]
// Source character channel: valid/ready plus command and byte.
// Depends on nothing.
`default_nettype none
interface jst_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] char_code;

   modport source (output valid, command, char_code, input ready);
   modport sink   (input valid, command, char_code, output ready);
endinterface
`default_nettype wire

[hdl/jst_rsp_if.sv]
// Token result channel: valid/ready plus the token fields.
// Depends on nothing.
`default_nettype none
interface jst_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [4:0]  keyword_index;
   logic [7:0]  symbol_char;
   logic        symbol_has_equals;
   logic [14:0] int_value;
   logic [7:0]  text_char;
   logic [15:0] token_line;
   logic [2:0]  error_code;
   logic        last;

   modport source (output valid, token_kind, keyword_index, symbol_char, symbol_has_equals,
                   int_value, text_char, token_line, error_code, last, input ready);
   modport sink   (input valid, token_kind, keyword_index, symbol_char, symbol_has_equals,
                   int_value, text_char, token_line, error_code, last, output ready);
endinterface
`default_nettype wire

[hdl/jst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module jst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

[hdl/jst_ctrl.sv]
// Sequencer for the tokenizer: steps each accepted character through
// mode handling, identifier runs, idle dispatch and end. Uses jst_pkg.
`default_nettype none
module jst_ctrl import jst_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire dp_status_type status,
   output      dp_cmd_type    cmd
);
   ctrl_state_type state_ff, state_in;
   logic           fire;

   assign fire = !status.emit || status.slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_WAIT: begin
            if (req_valid) begin
               state_in = ST_MODE;
            end
         end
         ST_MODE: begin
            if (fire) begin
               if (status.start_run) begin
                  state_in = ST_RUN;
               end else if (status.redispatch) begin
                  state_in = ST_IDLE;
               end else if (status.is_end) begin
                  state_in = ST_END;
               end else begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_RUN: begin
            if (fire && status.run_done) begin
               state_in = status.is_end ? ST_END : ST_IDLE;
            end
         end
         ST_IDLE, ST_END: begin
            if (fire) begin
               state_in = ST_WAIT;
            end
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.fire  = 1'b0;
      cmd.take  = 1'b0;
      case (state_ff)
         ST_WAIT: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_MODE: begin
            cmd.op   = OP_MODE;
            cmd.fire = fire;
         end
         ST_RUN: begin
            cmd.op   = OP_RUN;
            cmd.fire = fire;
         end
         ST_IDLE: begin
            cmd.op   = OP_IDLE;
            cmd.fire = fire;
         end
         ST_END: begin
            cmd.op   = OP_END;
            cmd.fire = fire;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end
endmodule
`default_nettype wire

[hdl/jst_dp.sv]
// Tokenizer datapath: scan state, word buffer, keyword filter, number
// accumulator, line counter and the result register. Uses jst_pkg, jst_ram.
`default_nettype none
module jst_dp import jst_pkg::*; #(
   parameter int MAX_WORD = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_cmd_type    cmd,
   output      dp_status_type status,
   input  wire logic          req_command,
   input  wire logic [7:0]    req_char_code,
   input  wire logic          rsp_ready,
   output      logic          rsp_valid,
   output      logic [2:0]    rsp_token_kind,
   output      logic [4:0]    rsp_keyword_index,
   output      logic [7:0]    rsp_symbol_char,
   output      logic          rsp_symbol_has_equals,
   output      logic [14:0]   rsp_int_value,
   output      logic [7:0]    rsp_text_char,
   output      logic [15:0]   rsp_token_line,
   output      logic [2:0]    rsp_error_code,
   output      logic          rsp_last
);
   localparam int AW = $clog2(MAX_WORD);
   localparam int LW = $clog2(MAX_WORD + 1);

   // latched input item
   logic          end_ff;
   logic [7:0]    char_ff;

   scan_mode_type mode_ff, mode_in;
   logic          star_ff, star_in;
   logic [7:0]    pend_ff, pend_in;
   logic [LW-1:0] len_ff, len_in;
   logic [14:0]   acc_ff, acc_in;
   logic [15:0]   line_ff, line_in;
   logic [15:0]   start_ff, start_in;
   logic [KW_COUNT-1:0] mask_ff, mask_in;
   logic [AW-1:0] run_idx_ff, run_idx_in;

   logic          valid_ff, valid_in;
   logic [2:0]    kind_ff, kind_in;
   logic [4:0]    kw_ff, kw_in;
   logic [7:0]    sym_ff, sym_in;
   logic          eq_ff, eq_in;
   logic [14:0]   iv_ff, iv_in;
   logic [7:0]    text_ff, text_in;
   logic [15:0]   tline_ff, tline_in;
   logic [2:0]    err_ff, err_in;
   logic          last_ff, last_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_rdata;

   logic [7:0]          lc;
   logic [KW_COUNT-1:0] mask_first, mask_next;
   logic                kw_found;
   logic [4:0]          kw_idx;
   logic [18:0]         num_next;
   logic [15:0]         line_bump;
   logic                slot_free;
   logic                do_idle;
   logic                emit;
   logic                redispatch;
   logic                start_run;
   logic                run_done;

   assign lc        = to_lower(char_ff);
   assign slot_free = !valid_ff || rsp_ready;
   assign num_next  = 19'(acc_ff) * 19'd10 + 19'(char_ff - CH_ZERO);
   assign line_bump = (line_ff != LINE_MAX) ? line_ff + 16'd1 : line_ff;
   assign run_done  = (LW'(run_idx_ff) + LW'(1)) == len_ff;

   always_comb begin
      mask_first = '0;
      mask_next  = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         mask_first[k] = kw_char(k, 0) == lc;
         mask_next[k]  = kw_char(k, int'(len_ff)) == lc;
      end
   end

   always_comb begin
      kw_found = 1'b0;
      kw_idx   = '0;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (mask_ff[k] && (int'(len_ff) == kw_len(k))) begin
            kw_found = 1'b1;
            kw_idx   = 5'(k);
         end
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      star_in    = star_ff;
      pend_in    = pend_ff;
      len_in     = len_ff;
      acc_in     = acc_ff;
      line_in    = line_ff;
      start_in   = start_ff;
      mask_in    = mask_ff;
      run_idx_in = run_idx_ff;
      ram_we     = 1'b0;
      ram_waddr  = len_ff[AW-1:0];
      emit       = 1'b0;
      redispatch = 1'b0;
      start_run  = 1'b0;
      do_idle    = 1'b0;
      kind_in    = KIND_SYMBOL;
      kw_in      = '0;
      sym_in     = '0;
      eq_in      = 1'b0;
      iv_in      = '0;
      text_in    = '0;
      tline_in   = start_ff;
      err_in     = ERR_NONE;
      last_in    = 1'b1;

      case (cmd.op)
         OP_MODE: begin
            if (end_ff) begin
               last_in = 1'b0;
               case (mode_ff)
                  MODE_SLASH: begin
                     emit   = 1'b1;
                     sym_in = CH_SLASH;
                  end
                  MODE_ANGLE: begin
                     emit   = 1'b1;
                     sym_in = pend_ff;
                  end
                  MODE_NUMBER: begin
                     emit    = 1'b1;
                     kind_in = KIND_INTEGER;
                     iv_in   = acc_ff;
                  end
                  MODE_WORD: begin
                     if (kw_found) begin
                        emit    = 1'b1;
                        kind_in = KIND_KEYWORD;
                        kw_in   = kw_idx;
                     end else begin
                        start_run  = 1'b1;
                        run_idx_in = '0;
                     end
                  end
                  MODE_STRING: begin
                     emit    = 1'b1;
                     kind_in = KIND_ERROR;
                     err_in  = ERR_UNCLOSED;
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end else begin
               case (mode_ff)
                  MODE_IDLE: begin
                     do_idle = 1'b1;
                  end
                  MODE_SLASH: begin
                     if (char_ff == CH_SLASH) begin
                        mode_in = MODE_LINE;
                     end else if (char_ff == CH_STAR) begin
                        mode_in = MODE_BLOCK;
                        star_in = 1'b0;
                     end else begin
                        emit       = 1'b1;
                        sym_in     = CH_SLASH;
                        mode_in    = MODE_IDLE;
                        redispatch = 1'b1;
                     end
                  end
                  MODE_LINE: begin
                     if (char_ff == CH_NL) begin
                        line_in = line_bump;
                        mode_in = MODE_IDLE;
                     end
                  end
                  MODE_BLOCK: begin
                     if (char_ff == CH_NL) begin
                        line_in = line_bump;
                     end
                     if (star_ff && (char_ff == CH_SLASH)) begin
                        mode_in = MODE_IDLE;
                        star_in = 1'b0;
                     end else begin
                        star_in = char_ff == CH_STAR;
                     end
                  end
                  MODE_ANGLE: begin
                     emit    = 1'b1;
                     sym_in  = pend_ff;
                     mode_in = MODE_IDLE;
                     if (char_ff == CH_EQ) begin
                        eq_in = 1'b1;
                     end else begin
                        redispatch = 1'b1;
                     end
                  end
                  MODE_STRING: begin
                     emit = 1'b1;
                     if (char_ff == CH_NL) begin
                        kind_in  = KIND_ERROR;
                        err_in   = ERR_NL_STR;
                        tline_in = line_ff;
                        mode_in  = MODE_HALT;
                     end else if (char_ff == CH_QUOTE) begin
                        kind_in = KIND_STR_END;
                        mode_in = MODE_IDLE;
                     end else begin
                        kind_in = KIND_STR_CHAR;
                        text_in = char_ff;
                     end
                  end
                  MODE_NUMBER: begin
                     if (is_digit(char_ff)) begin
                        if (num_next > 19'(INT_MAX)) begin
                           emit     = 1'b1;
                           kind_in  = KIND_ERROR;
                           err_in   = ERR_OVERFLOW;
                           iv_in    = INT_MAX;
                           tline_in = line_ff;
                           mode_in  = MODE_HALT;
                        end else begin
                           acc_in = num_next[14:0];
                        end
                     end else begin
                        emit       = 1'b1;
                        kind_in    = KIND_INTEGER;
                        iv_in      = acc_ff;
                        mode_in    = MODE_IDLE;
                        redispatch = 1'b1;
                     end
                  end
                  MODE_WORD: begin
                     if (is_word_char(char_ff)) begin
                        if (len_ff >= LW'(MAX_WORD)) begin
                           emit     = 1'b1;
                           kind_in  = KIND_ERROR;
                           err_in   = ERR_LONG_ID;
                           tline_in = line_ff;
                           mode_in  = MODE_HALT;
                        end else begin
                           ram_we  = 1'b1;
                           len_in  = len_ff + LW'(1);
                           mask_in = mask_ff & mask_next;
                        end
                     end else begin
                        mode_in    = MODE_IDLE;
                        redispatch = 1'b1;
                        if (kw_found) begin
                           emit    = 1'b1;
                           kind_in = KIND_KEYWORD;
                           kw_in   = kw_idx;
                        end else begin
                           start_run  = 1'b1;
                           run_idx_in = '0;
                        end
                     end
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
               if (redispatch) begin
                  last_in = !idle_emits(char_ff);
               end
            end
         end
         OP_IDLE: begin
            do_idle = 1'b1;
         end
         OP_RUN: begin
            emit    = 1'b1;
            kind_in = KIND_IDENT;
            text_in = ram_rdata;
            last_in = run_done && !end_ff && !idle_emits(char_ff);
            if (cmd.fire && !run_done) begin
               run_idx_in = run_idx_ff + AW'(1);
            end
         end
         OP_END: begin
            emit     = 1'b1;
            kind_in  = KIND_END;
            tline_in = line_ff;
            mode_in  = MODE_IDLE;
            star_in  = 1'b0;
            pend_in  = '0;
            len_in   = '0;
            acc_in   = '0;
            line_in  = 16'd1;
            start_in = 16'd1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      if (do_idle) begin
         last_in  = 1'b1;
         tline_in = line_ff;
         if (char_ff == CH_NL) begin
            line_in = line_bump;
         end else if (is_space(char_ff)) begin
            line_in = line_ff;
         end else if (char_ff == CH_SLASH) begin
            mode_in  = MODE_SLASH;
            start_in = line_ff;
         end else if ((char_ff == CH_LT) || (char_ff == CH_GT)) begin
            mode_in  = MODE_ANGLE;
            pend_in  = char_ff;
            start_in = line_ff;
         end else if (is_symbol(char_ff)) begin
            emit   = 1'b1;
            sym_in = char_ff;
         end else if (char_ff == CH_QUOTE) begin
            mode_in  = MODE_STRING;
            start_in = line_ff;
         end else if (is_digit(char_ff)) begin
            mode_in  = MODE_NUMBER;
            acc_in   = 15'(char_ff - CH_ZERO);
            start_in = line_ff;
         end else if (is_alpha(char_ff) || (char_ff == CH_US)) begin
            mode_in   = MODE_WORD;
            ram_we    = 1'b1;
            ram_waddr = '0;
            len_in    = LW'(1);
            mask_in   = mask_first;
            start_in  = line_ff;
         end else begin
            emit    = 1'b1;
            kind_in = KIND_ERROR;
            err_in  = ERR_INVALID;
            mode_in = MODE_HALT;
         end
      end
   end

   jst_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WORD)
   ) u_word_ram (
      .clock (clock),
      .we    (ram_we && cmd.fire),
      .waddr (ram_waddr),
      .wdata (char_ff),
      .raddr (run_idx_in),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (cmd.fire && emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         mode_ff    <= MODE_IDLE;
         star_ff    <= 1'b0;
         pend_ff    <= '0;
         len_ff     <= '0;
         acc_ff     <= '0;
         line_ff    <= 16'd1;
         start_ff   <= 16'd1;
         mask_ff    <= '0;
         run_idx_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.fire) begin
            mode_ff  <= mode_in;
            star_ff  <= star_in;
            pend_ff  <= pend_in;
            len_ff   <= len_in;
            acc_ff   <= acc_in;
            line_ff  <= line_in;
            start_ff <= start_in;
            mask_ff  <= mask_in;
         end
         run_idx_ff <= run_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         end_ff  <= req_command;
         char_ff <= req_char_code;
      end
      if (cmd.fire && emit) begin
         kind_ff  <= kind_in;
         kw_ff    <= kw_in;
         sym_ff   <= sym_in;
         eq_ff    <= eq_in;
         iv_ff    <= iv_in;
         text_ff  <= text_in;
         tline_ff <= tline_in;
         err_ff   <= err_in;
         last_ff  <= last_in;
      end
   end

   assign status.emit       = emit;
   assign status.slot_free  = slot_free;
   assign status.redispatch = redispatch;
   assign status.start_run  = start_run;
   assign status.run_done   = run_done;
   assign status.is_end     = end_ff;

   assign rsp_valid             = valid_ff;
   assign rsp_token_kind        = kind_ff;
   assign rsp_keyword_index     = kw_ff;
   assign rsp_symbol_char       = sym_ff;
   assign rsp_symbol_has_equals = eq_ff;
   assign rsp_int_value         = iv_ff;
   assign rsp_text_char         = text_ff;
   assign rsp_token_line        = tline_ff;
   assign rsp_error_code        = err_ff;
   assign rsp_last              = last_ff;
endmodule
`default_nettype wire

[hdl/jack_source_tokenizer_top.sv]
// Top level of the source tokenizer: joins sequencer and datapath.
// Uses jst_pkg, jst_req_if, jst_rsp_if, jst_ctrl, jst_dp.
//
//   channel   direction  handshake     payload
//   req_chan  in         valid/ready   command, char_code
//   rsp_chan  out        valid/ready   token fields, last
//
// A character is accepted, then handled in the mode step; one that ends a
// pending token is dispatched again in an idle step, and an end command
// adds an end step. An identifier that is no keyword is then read from the
// word RAM, one a cycle unless stalled. The result register stalls the
// sequencer while it holds an untaken result. Reset is synchronous.
`default_nettype none
module jack_source_tokenizer_top import jst_pkg::*; #(
   parameter int MAX_WORD = 16
) (
   input wire logic clock,
   input wire logic reset,
   jst_req_if.sink  req_chan,
   jst_rsp_if.source rsp_chan
);
   dp_cmd_type    cmd;
   dp_status_type status;

   jst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   jst_dp #(
      .MAX_WORD (MAX_WORD)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_command           (req_chan.command),
      .req_char_code         (req_chan.char_code),
      .rsp_ready             (rsp_chan.ready),
      .rsp_valid             (rsp_chan.valid),
      .rsp_token_kind        (rsp_chan.token_kind),
      .rsp_keyword_index     (rsp_chan.keyword_index),
      .rsp_symbol_char       (rsp_chan.symbol_char),
      .rsp_symbol_has_equals (rsp_chan.symbol_has_equals),
      .rsp_int_value         (rsp_chan.int_value),
      .rsp_text_char         (rsp_chan.text_char),
      .rsp_token_line        (rsp_chan.token_line),
      .rsp_error_code        (rsp_chan.error_code),
      .rsp_last              (rsp_chan.last)
   );
endmodule
`default_nettype wire

[hdl/jst_checker.sv]
// Port-level checks on the tokenizer top, attached by bind.
// Uses jst_pkg.
`default_nettype none
module jst_checker import jst_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_kind,
   input wire logic [2:0] rsp_error,
   input wire logic       rsp_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled result changed");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_END) |-> rsp_last)
      else $error("end result not marked last");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_ERROR) == (rsp_error != ERR_NONE)))
      else $error("error code does not match kind");

   a_no_accept_mid_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("new item taken before current one finished");
endmodule

bind jack_source_tokenizer_top jst_checker u_jst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.token_kind),
   .rsp_error (rsp_chan.error_code),
   .rsp_last  (rsp_chan.last)
);
`default_nettype wire
